[hw/rtl/iphc_pkg.sv]
package iphc_pkg;

  localparam int DEF_ADDRESS_ENTRIES   = 16;
  localparam int DEF_PORTS_PER_ADDRESS = 8;
  localparam int DEF_COUNT_WIDTH       = 32;

  localparam int IP_W     = 32;
  localparam int PORT_W   = 16;
  localparam int SLOT_O_W = 4;
  localparam int COUNT_O_W = 32;

  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_FIND = 2'd1;
  localparam logic [1:0] ACT_HIT  = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [1:0] ST_EXISTING  = 2'd0;
  localparam logic [1:0] ST_NEW       = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_FIND,
    OP_HIT,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_SLOT,
    S_PORT,
    S_PICK,
    S_INC,
    S_DONE
  } back_state_t;

endpackage

[hw/rtl/iphc_ram.sv]
module iphc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/iphc_front.sv]
module iphc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [1:0]                    action,
  input  logic [iphc_pkg::IP_W-1:0]     ip_address,
  input  logic [iphc_pkg::PORT_W-1:0]   port_number,
  output logic                          q_valid,
  output iphc_pkg::item_t               q_item,
  input  logic                          q_pop
);
  import iphc_pkg::*;

  // two-entry queue between decode and the table engine
  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  item_t      decoded;
  logic       push;
  logic       pop;

  always_comb begin
    decoded.ip   = ip_address;
    decoded.port = port_number;
    unique case (action)
      ACT_ADD:  decoded.op = OP_ADD;
      ACT_FIND: decoded.op = OP_FIND;
      ACT_HIT:  decoded.op = OP_HIT;
      ACT_NONE: decoded.op = OP_NOP;
    endcase
  end

  assign item_stall = (fill == 2'd2);
  assign push       = item_valid && !item_stall;
  assign q_valid    = (fill != 2'd0);
  assign pop        = q_pop && q_valid;
  assign q_item     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

[hw/rtl/iphc_back.sv]
module iphc_back #(
  parameter int ADDRESS_ENTRIES   = iphc_pkg::DEF_ADDRESS_ENTRIES,
  parameter int PORTS_PER_ADDRESS = iphc_pkg::DEF_PORTS_PER_ADDRESS,
  parameter int COUNT_WIDTH       = iphc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  iphc_pkg::item_t                  q_item,
  output logic                             q_pop,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [1:0]                       status,
  output logic [iphc_pkg::SLOT_O_W-1:0]    ip_slot,
  output logic [iphc_pkg::COUNT_O_W-1:0]   port_count
);
  import iphc_pkg::*;

  localparam int SLOT_W  = ADDRESS_ENTRIES > 1 ? $clog2(ADDRESS_ENTRIES) : 1;
  localparam int AFILL_W = $clog2(ADDRESS_ENTRIES + 1);
  localparam int PIDX_W  = PORTS_PER_ADDRESS > 1 ? $clog2(PORTS_PER_ADDRESS) : 1;
  localparam int PFILL_W = $clog2(PORTS_PER_ADDRESS + 1);
  localparam int ROW_W   = PORTS_PER_ADDRESS * PORT_W + PFILL_W;
  localparam int CNT_DEPTH = ADDRESS_ENTRIES * PORTS_PER_ADDRESS;
  localparam int CIDX_W  = CNT_DEPTH > 1 ? $clog2(CNT_DEPTH) : 1;

  back_state_t state;
  back_state_t state_next;

  // address table: entries below addr_fill are live (inserts only ever append)
  logic [IP_W-1:0]          tags [ADDRESS_ENTRIES];
  logic [AFILL_W-1:0]       addr_fill;
  logic [ADDRESS_ENTRIES-1:0] addr_match;

  op_t                      op;
  logic [IP_W-1:0]          ip;
  logic [PORT_W-1:0]        port;
  logic [SLOT_W-1:0]        slot;
  logic                     fresh;

  logic [PORT_W-1:0]        row_tags [PORTS_PER_ADDRESS];
  logic [PFILL_W-1:0]       row_fill;
  logic [PORTS_PER_ADDRESS-1:0] port_match;
  logic [CIDX_W-1:0]        cidx;

  logic [1:0]               res_status;
  logic [SLOT_W-1:0]        res_slot;
  logic [COUNT_WIDTH-1:0]   res_count;

  // encoders and decisions
  logic                     addr_found;
  logic [SLOT_W-1:0]        addr_enc;
  logic                     addr_full;
  logic [SLOT_W-1:0]        sel_slot;
  logic                     port_found;
  logic [PIDX_W-1:0]        port_enc;
  logic                     row_full;
  logic [PIDX_W-1:0]        free_idx;
  logic [PFILL_W-1:0]       fill_eff;
  logic [CIDX_W-1:0]        row_base;

  // memories
  logic                     row_rd_en;
  logic [ROW_W-1:0]         row_rd;
  logic                     row_wr_en;
  logic [ROW_W-1:0]         row_wr;
  logic [SLOT_W-1:0]        row_wr_addr;
  logic [ROW_W-1:0]         row_wr_data;
  logic                     cnt_rd_en;
  logic [CIDX_W-1:0]        cnt_rd_addr;
  logic [COUNT_WIDTH-1:0]   cnt_rd;
  logic                     cnt_wr_en;
  logic [CIDX_W-1:0]        cnt_wr_addr;
  logic [COUNT_WIDTH-1:0]   cnt_wr;
  logic [COUNT_WIDTH-1:0]   cnt_inc;

  logic                     load_out;
  logic [SLOT_W+SLOT_O_W-1:0] slot_wide;
  logic [COUNT_WIDTH+COUNT_O_W-1:0] count_wide;

  always_comb begin
    addr_found = 1'b0;
    addr_enc   = '0;
    for (int i = ADDRESS_ENTRIES - 1; i >= 0; i--) begin
      if (addr_match[i]) begin
        addr_found = 1'b1;
        addr_enc   = SLOT_W'(i);
      end
    end
  end

  assign addr_full = (addr_fill == AFILL_W'(ADDRESS_ENTRIES));
  assign sel_slot  = addr_found ? addr_enc : addr_fill[SLOT_W-1:0];

  always_comb begin
    port_found = 1'b0;
    port_enc   = '0;
    for (int j = PORTS_PER_ADDRESS - 1; j >= 0; j--) begin
      if (port_match[j]) begin
        port_found = 1'b1;
        port_enc   = PIDX_W'(j);
      end
    end
  end

  assign row_full = (row_fill == PFILL_W'(PORTS_PER_ADDRESS));
  assign free_idx = row_fill[PIDX_W-1:0];
  assign fill_eff = fresh ? '0 : row_rd[PFILL_W-1:0];
  assign row_base = CIDX_W'(slot) * CIDX_W'(PORTS_PER_ADDRESS);

  always_comb begin
    row_wr[PFILL_W-1:0] = row_fill + PFILL_W'(1);
    for (int j = 0; j < PORTS_PER_ADDRESS; j++) begin
      row_wr[PFILL_W + j*PORT_W +: PORT_W] =
        (free_idx == PIDX_W'(j)) ? port : row_tags[j];
    end
  end

  assign cnt_inc = (cnt_rd == '1) ? cnt_rd : cnt_rd + COUNT_WIDTH'(1);

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    row_rd_en   = 1'b0;
    row_wr_en   = 1'b0;
    row_wr_addr = slot;
    row_wr_data = row_wr;
    cnt_rd_en   = 1'b0;
    cnt_rd_addr = row_base + CIDX_W'(port_enc);
    cnt_wr_en   = 1'b0;
    cnt_wr_addr = cidx;
    cnt_wr      = cnt_inc;
    load_out    = 1'b0;
    unique case (state)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH: state_next = S_SLOT;
      S_SLOT: begin
        // a newly taken slot starts with an empty port row
        if ((op == OP_ADD || op == OP_HIT) && !addr_found && !addr_full) begin
          row_wr_en   = 1'b1;
          row_wr_addr = sel_slot;
          row_wr_data = '0;
        end
        if (op == OP_HIT && (addr_found || !addr_full)) begin
          row_rd_en  = 1'b1;
          state_next = S_PORT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_PORT: state_next = S_PICK;
      S_PICK: begin
        if (port_found) begin
          cnt_rd_en  = 1'b1;
          state_next = S_INC;
        end else begin
          if (!row_full) begin
            row_wr_en   = 1'b1;
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = row_base + CIDX_W'(free_idx);
            cnt_wr      = COUNT_WIDTH'(1);
          end
          state_next = S_DONE;
        end
      end
      S_INC: begin
        cnt_wr_en  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_fill <= '0;
    end else if (state == S_SLOT && (op == OP_ADD || op == OP_HIT) &&
                 !addr_found && !addr_full) begin
      addr_fill <= addr_fill + AFILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op   <= q_item.op;
        ip   <= q_item.ip;
        port <= q_item.port;
      end
      S_MATCH: begin
        for (int i = 0; i < ADDRESS_ENTRIES; i++) begin
          addr_match[i] <= (AFILL_W'(i) < addr_fill) && (tags[i] == ip);
        end
      end
      S_SLOT: begin
        slot  <= sel_slot;
        fresh <= !addr_found;
        res_count <= '0;
        priority if (op == OP_FIND) begin
          res_status <= addr_found ? ST_EXISTING : ST_NOT_FOUND;
          res_slot   <= addr_found ? addr_enc : '0;
        end else if (op == OP_NOP) begin
          res_status <= ST_NOT_FOUND;
          res_slot   <= '0;
        end else if (!addr_found && addr_full) begin
          res_status <= ST_FULL;
          res_slot   <= '0;
        end else begin
          if (!addr_found) begin
            tags[addr_fill[SLOT_W-1:0]] <= ip;
          end
          res_status <= addr_found ? ST_EXISTING : ST_NEW;
          res_slot   <= sel_slot;
        end
      end
      S_PORT: begin
        row_fill <= fill_eff;
        for (int j = 0; j < PORTS_PER_ADDRESS; j++) begin
          row_tags[j]   <= row_rd[PFILL_W + j*PORT_W +: PORT_W];
          port_match[j] <= (PFILL_W'(j) < fill_eff) &&
                           (row_rd[PFILL_W + j*PORT_W +: PORT_W] == port);
        end
      end
      S_PICK: begin
        cidx     <= cnt_rd_addr;
        res_slot <= slot;
        if (!port_found) begin
          res_status <= row_full ? ST_FULL : ST_NEW;
          res_count  <= row_full ? '0 : COUNT_WIDTH'(1);
        end
      end
      S_INC: begin
        res_status <= ST_EXISTING;
        res_count  <= cnt_inc;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assign slot_wide  = {{SLOT_O_W{1'b0}}, res_slot};
  assign count_wide = {{COUNT_O_W{1'b0}}, res_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status     <= res_status;
      ip_slot    <= slot_wide[SLOT_O_W-1:0];
      port_count <= count_wide[COUNT_O_W-1:0];
    end
  end

  // one row per address slot: fill count in the low bits, then the port tags
  iphc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ADDRESS_ENTRIES)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (row_wr_en),
    .wr_addr (row_wr_addr),
    .wr_data (row_wr_data),
    .rd_en   (row_rd_en),
    .rd_addr (sel_slot),
    .rd_data (row_rd)
  );

  iphc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (CNT_DEPTH)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rd)
  );

endmodule

[hw/rtl/ip_port_hit_counter_table.sv]
// channel   handshake                  payload
// item      item_valid / item_stall    action, ip_address, port_number
// result    result_valid / result_stall status, ip_slot, port_count
//
// Add and find finish after the address compare; record hit goes on through a port row
// read and a counter read-modify-write. Items wait in the two-item input queue, and the
// engine handles one item at a time.
// Reset clears the address fill count; a port row is emptied when its address is
// inserted, and counters are written before they are read.
// The input queue keeps taking items, until both its entries are full, while a result waits in the output register.
module ip_port_hit_counter_table #(
  parameter int ADDRESS_ENTRIES   = iphc_pkg::DEF_ADDRESS_ENTRIES,
  parameter int PORTS_PER_ADDRESS = iphc_pkg::DEF_PORTS_PER_ADDRESS,
  parameter int COUNT_WIDTH       = iphc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [1:0]                     action,
  input  logic [iphc_pkg::IP_W-1:0]      ip_address,
  input  logic [iphc_pkg::PORT_W-1:0]    port_number,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [1:0]                     status,
  output logic [iphc_pkg::SLOT_O_W-1:0]  ip_slot,
  output logic [iphc_pkg::COUNT_O_W-1:0] port_count
);
  import iphc_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  iphc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .action      (action),
    .ip_address  (ip_address),
    .port_number (port_number),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  iphc_back #(
    .ADDRESS_ENTRIES   (ADDRESS_ENTRIES),
    .PORTS_PER_ADDRESS (PORTS_PER_ADDRESS),
    .COUNT_WIDTH       (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .ip_slot      (ip_slot),
    .port_count   (port_count)
  );

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import iphc_pkg::*;

  localparam int SLOTS = DEF_ADDRESS_ENTRIES;
  localparam int PORTS = DEF_PORTS_PER_ADDRESS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 150;

  typedef struct packed {
    logic [1:0]           status;
    logic [SLOT_O_W-1:0]  slot;
    logic [COUNT_O_W-1:0] count;
  } reply_t;

  class hit_table_tracker;
    bit [IP_W-1:0]            addr_tag[SLOTS];
    bit                       addr_used[SLOTS];
    bit [PORT_W-1:0]          port_tag[SLOTS*PORTS];
    bit                       port_used[SLOTS*PORTS];
    bit [DEF_COUNT_WIDTH-1:0] hits[SLOTS*PORTS];
    reply_t                   awaited_replies[$];
    int                       errors;

    function int find_slot(bit [IP_W-1:0] ip);
      for (int i = 0; i < SLOTS; i++) begin
        if (addr_used[i] && addr_tag[i] == ip) return i;
      end
      return -1;
    endfunction

    function int claim_slot(input bit [IP_W-1:0] ip, output bit fresh);
      int s;
      s = find_slot(ip);
      fresh = 1'b0;
      if (s >= 0) return s;
      for (int i = 0; i < SLOTS; i++) begin
        if (!addr_used[i]) begin
          addr_used[i] = 1'b1;
          addr_tag[i] = ip;
          fresh = 1'b1;
          return i;
        end
      end
      return -1;
    endfunction

    function void take_request(logic [1:0] act, logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
      reply_t r;
      int s;
      int hit_e;
      int free_e;
      bit fresh;
      r.status = ST_NOT_FOUND;
      r.slot = '0;
      r.count = '0;
      case (act)
        ACT_ADD: begin
          s = claim_slot(ip, fresh);
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            r.status = fresh ? ST_NEW : ST_EXISTING;
            r.slot = SLOT_O_W'(s);
          end
        end
        ACT_FIND: begin
          s = find_slot(ip);
          if (s >= 0) begin
            r.status = ST_EXISTING;
            r.slot = SLOT_O_W'(s);
          end
        end
        ACT_HIT: begin
          s = claim_slot(ip, fresh);
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            r.slot = SLOT_O_W'(s);
            hit_e = -1;
            free_e = -1;
            for (int j = s * PORTS; j < (s + 1) * PORTS; j++) begin
              if (port_used[j]) begin
                if (hit_e < 0 && port_tag[j] == port) hit_e = j;
              end else if (free_e < 0) begin
                free_e = j;
              end
            end
            if (hit_e >= 0) begin
              r.status = ST_EXISTING;
            end else if (free_e >= 0) begin
              hit_e = free_e;
              port_used[hit_e] = 1'b1;
              port_tag[hit_e] = port;
              hits[hit_e] = '0;
              r.status = ST_NEW;
            end else begin
              r.status = ST_FULL;
            end
            if (hit_e >= 0) begin
              if (hits[hit_e] != '1) hits[hit_e]++;
              r.count = COUNT_O_W'(hits[hit_e]);
            end
          end
        end
        default: ;
      endcase
      awaited_replies.push_back(r);
    endfunction

    function void compare_reply(logic [1:0] st, logic [SLOT_O_W-1:0] slot,
                                logic [COUNT_O_W-1:0] count);
      reply_t want;
      if (awaited_replies.size() == 0) begin
        $error("unexpected result: status %0d ip_slot %0d port_count %0d", st, slot, count);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        errors++;
      end
      if (slot !== want.slot) begin
        $error("ip_slot: expected %0d, actual %0d", want.slot, slot);
        errors++;
      end
      if (count !== want.count) begin
        $error("port_count: expected %0d, actual %0d", want.count, count);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic [1:0]           action = ACT_ADD;
  logic [IP_W-1:0]      ip_address = '0;
  logic [PORT_W-1:0]    port_number = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [1:0]           status;
  logic [SLOT_O_W-1:0]  ip_slot;
  logic [COUNT_O_W-1:0] port_count;

  hit_table_tracker tracker = new();

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  pressure_on = 1'b0;
  bit  pressure_done = 1'b0;
  int  hold_left = 0;
  int  cycles = 0;

  ip_port_hit_counter_table DUT (
    .clk,
    .rst,
    .item_valid,
    .item_stall,
    .action,
    .ip_address,
    .port_number,
    .result_valid,
    .result_stall,
    .status,
    .ip_slot,
    .port_count
  );

  always begin
    #2ns clk = 1'b1;
    #2ns clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: checks, random stall, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) tracker.compare_reply(status, ip_slot, port_count);
      if (pressure_on && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_item(logic [1:0] act, logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    action <= act;
    ip_address <= ip;
    port_number <= port;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    tracker.take_request(act, ip, port);
  endtask

  initial begin
    bit [IP_W-1:0]   ip_pool[20];
    bit [PORT_W-1:0] port_pool[10];
    int              sent;
    int              roll;
    logic [1:0]      act;
    logic [IP_W-1:0] ip;
    logic [PORT_W-1:0] port;

    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int i = 2; i < 20; i++) ip_pool[i] = $urandom;
    port_pool[0] = '0;
    port_pool[1] = '1;
    for (int i = 2; i < 10; i++) port_pool[i] = PORT_W'($urandom_range(65535));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 6;
    recv_idle_pct = 76;

    // directed: empty table, unused action, insert/find, port set full
    send_item(ACT_FIND, '0, '0);
    send_item(ACT_NONE, '1, '1);
    send_item(ACT_ADD, '0, '1);
    send_item(ACT_ADD, '0, '0);
    send_item(ACT_FIND, '0, '1);
    send_item(ACT_HIT, '1, '1);
    send_item(ACT_HIT, '1, '1);
    for (int p = 0; p < PORTS - 1; p++) send_item(ACT_HIT, '1, PORT_W'(p));
    send_item(ACT_HIT, '1, 16'h1234);
    send_item(ACT_HIT, '1, '1);
    send_item(ACT_HIT, '0, '0);
    send_item(ACT_FIND, 32'h8000_0001, 16'h8000);
    send_item(ACT_ADD, 32'h7fff_fffe, '0);
    send_item(ACT_HIT, '0, 16'h8000);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 76 : 0;
      recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 6 : 0;
      if (phase == 2) pressure_on = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        roll = $urandom_range(99);
        act = (roll < 15) ? ACT_ADD : (roll < 35) ? ACT_FIND : (roll < 95) ? ACT_HIT : ACT_NONE;
        ip = ($urandom_range(99) < 85) ? ip_pool[$urandom_range(19)] : $urandom;
        port = ($urandom_range(99) < 85) ? port_pool[$urandom_range(9)]
                                         : PORT_W'($urandom_range(65535));
        send_item(act, ip, port);
        sent++;
      end
    end
    item_valid <= 1'b0;

    while (tracker.awaited_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/iphc_pkg.sv
hw/rtl/iphc_ram.sv
hw/rtl/iphc_front.sv
hw/rtl/iphc_back.sv
hw/rtl/ip_port_hit_counter_table.sv
tb/testbench.sv
